### rtl/core/dmd_pkg.sv
// Shared types, constants and calendar helpers for the date-minus-days unit.
// No dependencies.
package dmd_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YMOD_W  = 9;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;

    // Gregorian cycle: the leap pattern repeats every 400 years
    localparam int                YEAR_CYCLE    = 400;
    localparam logic [YMOD_W-1:0] YMOD_LAST     = 9'd399;
    localparam logic [YMOD_W-1:0] YMOD_CENT_1   = 9'd100;
    localparam logic [YMOD_W-1:0] YMOD_CENT_2   = 9'd200;
    localparam logic [YMOD_W-1:0] YMOD_CENT_3   = 9'd300;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REDUCE = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } dmd_state_t;

    // leap test on the year modulo 400
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        logic century;
        century = (ymod == YMOD_CENT_1) || (ymod == YMOD_CENT_2) || (ymod == YMOD_CENT_3);
        return (ymod[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic              leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (month == MONTH_FEB)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if ((month == MONTH_APR) || (month == MONTH_JUN) ||
                 (month == MONTH_SEP) || (month == MONTH_NOV))
        begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

### rtl/core/dmd_subcmp.sv
// Shared subtract-and-compare unit of the date-minus-days unit.
// Depends on nothing; used by date_minus_days_unit for every iteration.
module dmd_subcmp #(
    parameter int W = 17
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         ge
);

    logic [W:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[W-1:0];
    assign ge   = !wide[W];

endmodule

### rtl/core/date_minus_days_unit.sv
// Top level of the date-minus-days unit: sequencer, date registers, output register.
// Depends on dmd_pkg and dmd_subcmp.

// Subtracts days_back days from a Gregorian date by borrowing one whole month per
// cycle. An item first reduces the year modulo 400 for the leap test, then borrows
// months, closes with the day subtraction and loads the output register once it is
// free; the reduction and the walk share a single subtract/compare unit. in_ready
// is high only between items, but a finished result waits in the output register
// while the next item is taken.
// A borrow out of January of year 0 clamps the result to 0000-01-01 with
// underflow set.
module date_minus_days_unit #(
    parameter int DAYS_WIDTH = 16,
    parameter int YEAR_WIDTH = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [YEAR_WIDTH-1:0]           start_year,
    input  logic [dmd_pkg::MONTH_W-1:0]     start_month,
    input  logic [dmd_pkg::DAY_W-1:0]       start_day,
    input  logic [DAYS_WIDTH-1:0]           days_back,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [YEAR_WIDTH-1:0]           result_year,
    output logic [dmd_pkg::MONTH_W-1:0]     result_month,
    output logic [dmd_pkg::DAY_W-1:0]       result_day,
    output logic                            underflow
);

    localparam int UW        = (DAYS_WIDTH > YEAR_WIDTH + 1) ? DAYS_WIDTH : YEAR_WIDTH + 1;
    localparam int RED_STEPS = (YEAR_WIDTH > 8) ? YEAR_WIDTH - 8 : 1;
    localparam int KW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam logic [KW-1:0] K_TOP = KW'(RED_STEPS - 1);

    dmd_pkg::dmd_state_t state_reg, state_next;

    logic [YEAR_WIDTH-1:0]        year_reg, year_next;
    logic [dmd_pkg::MONTH_W-1:0]  month_reg, month_next;
    logic [dmd_pkg::DAY_W-1:0]    day_reg, day_next;
    logic [DAYS_WIDTH-1:0]        left_reg, left_next;
    logic [UW-1:0]                res_reg, res_next;
    logic [dmd_pkg::YMOD_W-1:0]   ymod_reg, ymod_next;
    logic [KW-1:0]                k_reg, k_next;
    logic                         under_reg, under_next;

    logic                         out_valid_reg, out_valid_next;
    logic [YEAR_WIDTH-1:0]        oyear_reg, oyear_next;
    logic [dmd_pkg::MONTH_W-1:0]  omonth_reg, omonth_next;
    logic [dmd_pkg::DAY_W-1:0]    oday_reg, oday_next;
    logic                         ounder_reg, ounder_next;

    logic [UW-1:0] op_a, op_b, op_diff;
    logic          op_ge;
    logic          out_free;

    dmd_subcmp #(.W(UW)) u_subcmp (
        .a    (op_a),
        .b    (op_b),
        .diff (op_diff),
        .ge   (op_ge)
    );

    always_comb
    begin
        if (state_reg == dmd_pkg::ST_REDUCE)
        begin
            op_a = res_reg;
            op_b = UW'(dmd_pkg::YEAR_CYCLE) << k_reg;
        end
        else
        begin
            op_a = UW'(left_reg);
            op_b = UW'(day_reg);
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == dmd_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        left_next      = left_reg;
        res_next       = res_reg;
        ymod_next      = ymod_reg;
        k_next         = k_reg;
        under_next     = under_reg;
        out_valid_next = out_valid_reg && !out_ready;
        oyear_next     = oyear_reg;
        omonth_next    = omonth_reg;
        oday_next      = oday_reg;
        ounder_next    = ounder_reg;

        unique case (state_reg)
            dmd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    year_next  = start_year;
                    day_next   = start_day;
                    left_next  = days_back;
                    res_next   = UW'(start_year);
                    k_next     = K_TOP;
                    under_next = 1'b0;
                    if (start_month == '0)
                    begin
                        month_next = dmd_pkg::MONTH_JAN;
                    end
                    else if (start_month > dmd_pkg::MONTH_DEC)
                    begin
                        month_next = dmd_pkg::MONTH_DEC;
                    end
                    else
                    begin
                        month_next = start_month;
                    end
                    state_next = dmd_pkg::ST_REDUCE;
                end
            end

            dmd_pkg::ST_REDUCE:
            begin
                // restoring reduction of the year by 400 * 2^k
                if (op_ge)
                begin
                    res_next = op_diff;
                end
                if (k_reg == '0)
                begin
                    ymod_next  = op_ge ? op_diff[dmd_pkg::YMOD_W-1:0]
                                       : res_reg[dmd_pkg::YMOD_W-1:0];
                    state_next = dmd_pkg::ST_WALK;
                end
                else
                begin
                    k_next = k_reg - KW'(1);
                end
            end

            dmd_pkg::ST_WALK:
            begin
                if (op_ge)
                begin
                    // borrow the whole current month
                    left_next = op_diff[DAYS_WIDTH-1:0];
                    if (month_reg == dmd_pkg::MONTH_JAN)
                    begin
                        if (year_reg == '0)
                        begin
                            under_next = 1'b1;
                            state_next = dmd_pkg::ST_FINISH;
                        end
                        else
                        begin
                            year_next  = year_reg - YEAR_WIDTH'(1);
                            ymod_next  = (ymod_reg == '0) ? dmd_pkg::YMOD_LAST
                                                          : ymod_reg - dmd_pkg::YMOD_W'(1);
                            month_next = dmd_pkg::MONTH_DEC;
                            day_next   = dmd_pkg::month_length(dmd_pkg::MONTH_DEC, 1'b0);
                        end
                    end
                    else
                    begin
                        // February is only reached from March, so the year holds
                        month_next = month_reg - dmd_pkg::MONTH_W'(1);
                        day_next   = dmd_pkg::month_length(month_reg - dmd_pkg::MONTH_W'(1),
                                                           dmd_pkg::is_leap(ymod_reg));
                    end
                end
                else
                begin
                    day_next   = day_reg - left_reg[dmd_pkg::DAY_W-1:0];
                    state_next = dmd_pkg::ST_FINISH;
                end
            end

            dmd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ounder_next    = under_reg;
                    if (under_reg)
                    begin
                        oyear_next  = '0;
                        omonth_next = dmd_pkg::MONTH_JAN;
                        oday_next   = dmd_pkg::DAY_FIRST;
                    end
                    else
                    begin
                        oyear_next  = year_reg;
                        omonth_next = month_reg;
                        oday_next   = day_reg;
                    end
                    state_next = dmd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dmd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        left_reg   <= left_next;
        res_reg    <= res_next;
        ymod_reg   <= ymod_next;
        k_reg      <= k_next;
        under_reg  <= under_next;
        oyear_reg  <= oyear_next;
        omonth_reg <= omonth_next;
        oday_reg   <= oday_next;
        ounder_reg <= ounder_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_year  = oyear_reg;
    assign result_month = omonth_reg;
    assign result_day   = oday_reg;
    assign underflow    = ounder_reg;

endmodule

### rtl/core/dmd_checker.sv
// Port-level checks for date_minus_days_unit, with the bind that attaches them.
// Depends on dmd_pkg and date_minus_days_unit.
module dmd_checker #(
    parameter int DAYS_WIDTH = 16,
    parameter int YEAR_WIDTH = 14
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [YEAR_WIDTH-1:0]           start_year,
    input logic [dmd_pkg::MONTH_W-1:0]     start_month,
    input logic [dmd_pkg::DAY_W-1:0]       start_day,
    input logic [DAYS_WIDTH-1:0]           days_back,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [YEAR_WIDTH-1:0]           result_year,
    input logic [dmd_pkg::MONTH_W-1:0]     result_month,
    input logic [dmd_pkg::DAY_W-1:0]       result_day,
    input logic                            underflow
);

    // a waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(start_year) &&
        $stable(start_month) && $stable(start_day) && $stable(days_back))
        else $error("input item changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_year) &&
        $stable(result_month) && $stable(result_day) && $stable(underflow))
        else $error("result changed while stalled");

    // an accepted item keeps the unit busy for at least the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting an item");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && underflow |-> result_year == '0 &&
        result_month == dmd_pkg::MONTH_JAN && result_day == dmd_pkg::DAY_FIRST)
        else $error("underflow result not clamped");

    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_month >= dmd_pkg::MONTH_JAN &&
        result_month <= dmd_pkg::MONTH_DEC && result_day != '0)
        else $error("result month or day out of range");

endmodule

bind date_minus_days_unit dmd_checker #(
    .DAYS_WIDTH (DAYS_WIDTH),
    .YEAR_WIDTH (YEAR_WIDTH)
) u_dmd_checker (.*);
